FILE: rtl/golomb_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Golomb encoder core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GOLOMB_ENCODER_CORE_ASSERT_SVH
`define GOLOMB_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GEC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg
// Shared types and constants of the Golomb encoder core.
// ----------------------------------------------------------------------------
package gec_pkg;

    localparam int VALUE_IN_W = 16;          // width of the value port
    localparam int DIV_W      = 16;          // divisor register width
    localparam int QUOT_W     = 12;          // holds any quotient up to 4095
    localparam int TAIL_W     = DIV_W + 1;   // zero bit plus remainder bits
    localparam int TLEN_W     = 5;           // 0..TAIL_W
    localparam int CODE_W     = 32;          // code_bits port width
    localparam int BCNT_W     = 6;           // bit_count port width

    // configuration register indexes
    localparam logic CFG_DIVISOR = 1'b0;
    localparam logic CFG_ZIGZAG  = 1'b1;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // One classified item: everything the back end needs to emit its chunks.
    // tail is left aligned: the terminating zero bit, then the remainder bits.
    typedef struct packed {
        logic                overflow;
        logic                sign_len;
        logic                sign;
        logic [QUOT_W-1:0]   quot;
        logic [TAIL_W-1:0]   tail;
        logic [TLEN_W-1:0]   tail_len;
    } t_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Smallest b with 2^b >= m (m >= 1).
    function automatic logic [TLEN_W-1:0] ceil_log2(input logic [DIV_W-1:0] m);
        logic [DIV_W-1:0]  v;
        logic [TLEN_W-1:0] b;
        v = m - DIV_W'(1);
        b = '0;
        for (int i = 0; i < DIV_W; i++) begin
            if (v[i]) begin
                b = TLEN_W'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/gec_front.sv
// ----------------------------------------------------------------------------
// gec_front
// Maps the signed value, divides it by m one bit per cycle and builds the
// code descriptor (overflow, quotient, truncated-binary remainder).
// ----------------------------------------------------------------------------
module gec_front import gec_pkg::*; #(
    parameter int VALUE_WIDTH  = 16,
    parameter int MAX_QUOTIENT = 1023
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_IN_W-1:0] i_value,
    input  logic [DIV_W-1:0]      i_divisor,
    input  logic                  i_zigzag,
    output logic                  o_push,
    output t_desc                 o_desc,
    input  logic                  i_full
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VW + 1);

    t_front_state        r_state, n_state;
    logic [VW-1:0]       r_n;        // dividend, becomes the quotient
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_m;
    logic                r_sign;
    logic                r_sign_len;
    logic [CNT_W-1:0]    r_cnt;

    logic                w_ready, w_accept, w_step;

    // input mapping
    logic [31:0]         w_ext;
    logic [VW-1:0]       w_raw, w_mag, w_zz, w_n;
    logic                w_neg;

    // divider step
    logic [DIV_W:0]      w_trial, w_diff;
    logic                w_ge;

    // descriptor
    logic                w_ovf;
    logic [TLEN_W-1:0]   w_b, w_rlen;
    logic [DIV_W:0]      w_thr, w_sum;
    logic                w_lt;
    logic [DIV_W-1:0]    w_rbits;

    assign w_ext = 32'(i_value);
    assign w_raw = w_ext[VW-1:0];
    assign w_neg = w_raw[VW-1];
    assign w_mag = w_neg ? (VW'(0) - w_raw) : w_raw;
    assign w_zz  = w_neg ? ({w_mag[VW-2:0], 1'b0} - VW'(1)) : {w_raw[VW-2:0], 1'b0};
    assign w_n   = i_zigzag ? w_zz : w_mag;

    assign w_trial = {r_rem, r_n[VW-1]};
    assign w_ge    = w_trial >= {1'b0, r_m};
    assign w_diff  = w_trial - {1'b0, r_m};

    assign w_ovf   = 32'(r_n) > 32'(MAX_QUOTIENT);
    assign w_b     = ceil_log2(r_m);
    assign w_thr   = (TAIL_W'(1) << w_b) - {1'b0, r_m};
    assign w_lt    = {1'b0, r_rem} < w_thr;
    assign w_sum   = {1'b0, r_rem} + w_thr;
    assign w_rbits = w_lt ? r_rem : w_sum[DIV_W-1:0];
    assign w_rlen  = w_lt ? (w_b - TLEN_W'(1)) : w_b;

    always_comb begin
        o_desc.overflow = w_ovf;
        o_desc.sign_len = r_sign_len;
        o_desc.sign     = r_sign;
        o_desc.quot     = QUOT_W'(r_n);
        o_desc.tail     = {1'b0, w_rbits << (TLEN_W'(DIV_W) - w_rlen)};
        o_desc.tail_len = w_rlen + TLEN_W'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: begin
                if (i_valid) n_state = FR_DIV;
            end
            FR_DIV: begin
                if (r_cnt == CNT_W'(VW - 1)) n_state = FR_PUSH;
            end
            FR_PUSH: begin
                if (!i_full) n_state = i_valid ? FR_DIV : FR_IDLE;
            end
            default: n_state = FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_ready = 1'b0;
        o_push  = 1'b0;
        w_step  = 1'b0;
        unique case (r_state)
            FR_IDLE: w_ready = 1'b1;
            FR_DIV:  w_step  = 1'b1;
            FR_PUSH: begin
                w_ready = !i_full;
                o_push  = !i_full;
            end
            default: ;
        endcase
    end

    assign o_stall  = !w_ready;
    assign w_accept = i_valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n        <= w_n;
            r_rem      <= '0;
            r_m        <= (i_divisor == '0) ? DIV_W'(1) : i_divisor;
            r_sign     <= w_neg;
            r_sign_len <= !i_zigzag;
            r_cnt      <= '0;
        end else if (w_step) begin
            r_n   <= {r_n[VW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

endmodule

FILE: rtl/gec_queue.sv
// ----------------------------------------------------------------------------
// gec_queue
// Two-entry descriptor queue between the divider and the chunk emitter.
// ----------------------------------------------------------------------------
module gec_queue import gec_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_desc         i_desc,
    input  logic          i_pop,
    output t_desc         o_desc,
    output t_queue_status o_status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0]   r_cnt;

    assign o_desc          = r_mem[r_rp];
    assign o_status.empty  = (r_cnt == '0);
    assign o_status.full   = (r_cnt == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/gec_back.sv
// ----------------------------------------------------------------------------
// gec_back
// Emits one descriptor as chunks: optional sign bit, run of ones, then the
// tail, one chunk per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module gec_back import gec_pkg::*; #(
    parameter int CHUNK_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_queue_status      i_status,
    input  t_desc              i_desc,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CODE_W-1:0]  o_code_bits,
    output logic [BCNT_W-1:0]  o_bit_count,
    output logic               o_last_chunk,
    output logic               o_overflow
);

    localparam int CW          = (CHUNK_WIDTH > CODE_W) ? CODE_W : CHUNK_WIDTH;
    localparam int MAX_RESULTS = 33;
    localparam int PAD_W       = CODE_W - TAIL_W;

    t_back_state         r_state, n_state;
    logic                r_sign_pend;
    logic                r_sign;
    logic [QUOT_W-1:0]   r_ones;
    logic [TAIL_W-1:0]   r_tail;
    logic [TLEN_W-1:0]   r_tlen;
    logic                r_ovf;
    logic [BCNT_W-1:0]   r_cnt;

    logic                r_o_valid;
    logic [CODE_W-1:0]   r_code;
    logic [BCNT_W-1:0]   r_bcnt;
    logic                r_last;
    logic                r_ovf_o;

    logic                w_advance, w_emit, w_done;
    logic [BCNT_W-1:0]   w_room1, w_room2, w_k1, w_k2, w_len;
    logic [63:0]         w_ones64;
    logic [CODE_W-1:0]   w_word, w_code;
    logic [QUOT_W-1:0]   w_ones_nx;
    logic [TLEN_W-1:0]   w_tlen_nx;
    logic                w_last;

    // chunk assembly, left aligned in a 32-bit word, then right aligned
    assign w_room1  = BCNT_W'(CW) - BCNT_W'(r_sign_pend);
    assign w_k1     = (r_ones < QUOT_W'(w_room1)) ? BCNT_W'(r_ones) : w_room1;
    assign w_room2  = w_room1 - w_k1;
    assign w_k2     = (BCNT_W'(r_tlen) < w_room2) ? BCNT_W'(r_tlen) : w_room2;
    assign w_len    = BCNT_W'(r_sign_pend) + w_k1 + w_k2;
    assign w_ones64 = ~({64{1'b1}} >> w_k1);
    assign w_word   = {r_sign_pend & r_sign, {(CODE_W-1){1'b0}}}
                    | (w_ones64[63:32] >> r_sign_pend)
                    | ({r_tail, {PAD_W{1'b0}}} >> (BCNT_W'(r_sign_pend) + w_k1));
    assign w_code   = w_word >> (BCNT_W'(CODE_W) - w_len);

    assign w_ones_nx = r_ones - QUOT_W'(w_k1);
    assign w_tlen_nx = r_tlen - TLEN_W'(w_k2);
    assign w_last    = ((w_ones_nx == '0) && (w_tlen_nx == '0))
                    || (r_cnt == BCNT_W'(MAX_RESULTS - 1));
    assign w_done    = r_ovf || w_last;

    assign w_advance = !r_o_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_status.empty) n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (w_advance && w_done) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop  = !i_status.empty;
            BK_EMIT: w_emit = w_advance;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sign_pend <= i_desc.sign_len;
            r_sign      <= i_desc.sign;
            r_ones      <= i_desc.quot;
            r_tail      <= i_desc.tail;
            r_tlen      <= i_desc.tail_len;
            r_ovf       <= i_desc.overflow;
            r_cnt       <= '0;
        end else if (w_emit) begin
            r_sign_pend <= 1'b0;
            r_ones      <= w_ones_nx;
            r_tail      <= r_tail << w_k2;
            r_tlen      <= w_tlen_nx;
            r_cnt       <= r_cnt + BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_ovf) begin
                r_code  <= '0;
                r_bcnt  <= '0;
                r_last  <= 1'b1;
                r_ovf_o <= 1'b1;
            end else begin
                r_code  <= w_code;
                r_bcnt  <= w_len;
                r_last  <= w_last;
                r_ovf_o <= 1'b0;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_code_bits  = r_code;
    assign o_bit_count  = r_bcnt;
    assign o_last_chunk = r_last;
    assign o_overflow   = r_ovf_o;

endmodule

FILE: rtl/golomb_encoder_core.sv
// Throughput: the front takes a new item only once the previous one is divided
//   and pushed, set by the bit-serial divider (one quotient bit a cycle); the
//   back emits one chunk a cycle unless the output stalls, after a load step per
//   item, and the two overlap through the queue.
// Reset (synchronous, active low): divisor 5, zigzag mode on, queue and output empty.
// ----------------------------------------------------------------------------
// golomb_encoder_core
// Golomb encoder: maps a signed value (zigzag or sign/magnitude), splits it
// into quotient and remainder by m, and streams the unary/truncated-binary
// code in chunks of up to CHUNK_WIDTH bits (capped at 32) with a last flag.
// ----------------------------------------------------------------------------
module golomb_encoder_core import gec_pkg::*; #(
    parameter int VALUE_WIDTH  = 16,
    parameter int MAX_QUOTIENT = 1023,
    parameter int CHUNK_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_IN_W-1:0] i_value,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CODE_W-1:0]     o_code_bits,
    output logic [BCNT_W-1:0]     o_bit_count,
    output logic                  o_last_chunk,
    output logic                  o_overflow,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [DIV_W-1:0]      i_cfg_data
);

    `include "golomb_encoder_core_assert.svh"

    localparam int CHUNK_CAP = (CHUNK_WIDTH > CODE_W) ? CODE_W : CHUNK_WIDTH;

    logic [DIV_W-1:0]  r_divisor;
    logic              r_zigzag;

    logic              w_push, w_pop;
    t_desc             w_desc_in, w_desc_out;
    t_queue_status     w_qstat;

    logic              w_ovf_shape_ok, w_len_ok;

    // Config must only be written while idle, so no shadowing is needed; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIV_W'(5);
            r_zigzag  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIVISOR: r_divisor <= i_cfg_data;
                CFG_ZIGZAG:  r_zigzag  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: value mapping, serial divide, remainder coding, overflow check.
    gec_front #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .MAX_QUOTIENT (MAX_QUOTIENT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_divisor (r_divisor),
        .i_zigzag  (r_zigzag),
        .o_push    (w_push),
        .o_desc    (w_desc_in),
        .i_full    (w_qstat.full)
    );

    // Decouples divider from chunk emission so each side stalls on its own.
    gec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_desc   (w_desc_in),
        .i_pop    (w_pop),
        .o_desc   (w_desc_out),
        .o_status (w_qstat)
    );

    // Back: chunk assembly with registered output.
    gec_back #(
        .CHUNK_WIDTH (CHUNK_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_status     (w_qstat),
        .i_desc       (w_desc_out),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_bits  (o_code_bits),
        .o_bit_count  (o_bit_count),
        .o_last_chunk (o_last_chunk),
        .o_overflow   (o_overflow)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign w_ovf_shape_ok = o_last_chunk && (o_bit_count == '0) && (o_code_bits == '0);
    assign w_len_ok       = (o_bit_count != '0) && (o_bit_count <= BCNT_W'(CHUNK_CAP));

    `GEC_ASSERT_IMP(a_no_push_full, w_push, !w_qstat.full, "push into a full queue")
    `GEC_ASSERT_NXT(a_push_lands, w_push, !w_qstat.empty, "pushed item missing from queue")
    `GEC_ASSERT_IMP(a_ovf_item, o_valid && o_overflow, w_ovf_shape_ok, "malformed overflow item")
    `GEC_ASSERT_IMP(a_chunk_len, o_valid && !o_overflow, w_len_ok, "chunk length out of range")

endmodule
